// ----- hw/rtl/pim_pkg.sv -----
`default_nettype none

package pim_pkg;

    // Widths fixed by the item and register formats
    localparam int CAPTURE_W   = 16;
    localparam int OVF_W       = 16;
    localparam int INTERVAL_W  = 32;
    localparam int THRESH_W    = 24;
    localparam int COUNT_W     = 8;
    localparam int PERCENT_W   = 7;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    // Parameter defaults
    localparam int TIMER_BITS_DEF    = 16;
    localparam int INTERVAL_BITS_DEF = 32;

    // Register reset values
    localparam logic [THRESH_W-1:0] THRESH_RESET = 24'd50000;
    localparam logic [COUNT_W-1:0]  IPR_RESET    = 8'd10;

    // Percentage divide: dividend is count * 100, fits in 15 bits
    localparam int DIVD_W    = 15;
    localparam int DIV_STEP_W = $clog2(DIVD_W);
    localparam logic [DIVD_W-1:0]    PCT_SCALE = 15'd100;
    localparam logic [PERCENT_W-1:0] PCT_MAX   = 7'd100;

    // Register indexes
    typedef enum logic [0:0] {
        REG_DIFF_THRESHOLD = 1'b0,
        REG_INTERVALS      = 1'b1
    } reg_index_t;

    // Request codes
    localparam logic REQ_OVERFLOW = 1'b0;
    localparam logic REQ_EDGE     = 1'b1;

endpackage

`default_nettype wire

// ----- hw/rtl/pnn50_interval_meter.sv -----
// Beat interval variability meter (pNN50 style).
// Input channel (in_valid / in_stall): each word is either a timer overflow
// tick (req_type 0) or a captured beat edge timestamp (req_type 1).
// Output channel (out_valid / out_stall): one word per edge that closes an
// interval, with the interval, the exceed flag, running counts, indicator
// level and, on the last interval of a reading, the percentage.
// Overflow ticks, the first edge and words after a finished reading give
// no result. An edge that closes an interval runs through a sequencer
// around one shared subtractor: interval, one or two difference passes, a
// threshold compare and a counter update (the first interval skips the
// difference passes and the compare), plus 15 restoring divide steps on the
// interval that completes the reading; then the output register is loaded.
// in_stall stays high while the sequencer is busy.
// If the receiver stalls, the result holds in the output register and the
// sequencer waits with the next result until the register frees.
// Reset clears the meter state and loads the register defaults
// (threshold 50000, 10 intervals per reading). After a reading completes,
// all further words are accepted and dropped until reset.
// Registers sit on an APB port: diff_threshold at 0x0, intervals at 0x4.
`default_nettype none

module pnn50_interval_meter
#(
    parameter int TIMER_BITS    = pim_pkg::TIMER_BITS_DEF,
    parameter int INTERVAL_BITS = pim_pkg::INTERVAL_BITS_DEF
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // APB register port
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [pim_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [pim_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [pim_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                  pready,
    // input channel
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic                             req_type,
    input  wire logic [pim_pkg::CAPTURE_W-1:0]    capture_time,
    // output channel
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic      [pim_pkg::INTERVAL_W-1:0]   interval_ticks,
    output logic                                  diff_exceeded,
    output logic      [pim_pkg::COUNT_W-1:0]      counted_intervals,
    output logic      [pim_pkg::COUNT_W-1:0]      exceeded_count,
    output logic                                  indicator,
    output logic                                  reading_valid,
    output logic      [pim_pkg::PERCENT_W-1:0]    hrv_percent
);
    import pim_pkg::*;

    localparam int CAP_W = (TIMER_BITS < CAPTURE_W) ? TIMER_BITS : CAPTURE_W;
    localparam int TOT_W = OVF_W + TIMER_BITS;
    localparam int SW    = (TOT_W > INTERVAL_BITS) ? TOT_W : INTERVAL_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INTERVAL,
        S_DIFF_FWD,
        S_DIFF_REV,
        S_THRESH,
        S_UPDATE,
        S_DIVIDE,
        S_EMIT
    } state_t;

    state_t                    state_reg;

    logic [THRESH_W-1:0]       thresh_reg;
    logic [COUNT_W-1:0]        ipr_reg;

    logic                      seen_first_reg;
    logic [CAP_W-1:0]          last_cap_reg;
    logic [CAP_W-1:0]          cap_reg;
    logic [OVF_W-1:0]          ovf_reg;
    logic [INTERVAL_BITS-1:0]  ival_reg;
    logic [INTERVAL_BITS-1:0]  prev_reg;
    logic [INTERVAL_BITS-1:0]  diff_reg;
    logic                      have_prev_reg;
    logic                      exceeded_reg;
    logic [COUNT_W-1:0]        icnt_reg;
    logic [COUNT_W-1:0]        ecnt_reg;
    logic                      ind_reg;
    logic                      finished_reg;
    logic                      done_reg;

    logic [DIVD_W-1:0]         dvd_reg;
    logic [DIVD_W-1:0]         quot_reg;
    logic [COUNT_W-1:0]        rem_reg;
    logic [DIV_STEP_W-1:0]     step_reg;

    logic                      out_valid_reg;
    logic [INTERVAL_W-1:0]     out_ival_reg;
    logic                      out_exc_reg;
    logic [COUNT_W-1:0]        out_icnt_reg;
    logic [COUNT_W-1:0]        out_ecnt_reg;
    logic                      out_ind_reg;
    logic                      out_done_reg;
    logic [PERCENT_W-1:0]      out_pct_reg;

    logic                      in_acc;
    logic                      cfg_wr;
    reg_index_t                cfg_idx;
    logic [SW-1:0]             sub_a;
    logic [SW-1:0]             sub_b;
    logic [SW:0]               sub_full;
    logic [SW-1:0]             sub_res;
    logic                      sub_borrow;
    logic [SW-1:0]             total;
    logic [COUNT_W-1:0]        target;
    logic [COUNT_W-1:0]        icnt_next;
    logic [COUNT_W-1:0]        ecnt_next;
    logic [COUNT_W:0]          partial;
    logic [PERCENT_W-1:0]      pct_next;

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign cfg_idx  = reg_index_t'(paddr[2]);

    always_comb
    begin
        unique case (cfg_idx)
            REG_DIFF_THRESHOLD: prdata = APB_DATA_W'(thresh_reg);
            REG_INTERVALS:      prdata = APB_DATA_W'(ipr_reg);
            default:            prdata = '0;
        endcase
    end

    assign total   = (SW'(ovf_reg) << TIMER_BITS) | SW'(cap_reg);
    assign target  = (ipr_reg == '0) ? COUNT_W'(1) : ipr_reg;
    assign partial = {rem_reg, dvd_reg[DIVD_W-1]};

    // shared subtractor operand select
    always_comb
    begin
        unique case (state_reg)
            S_INTERVAL:
            begin
                sub_a = total;
                sub_b = SW'(last_cap_reg);
            end
            S_DIFF_FWD:
            begin
                sub_a = SW'(ival_reg);
                sub_b = SW'(prev_reg);
            end
            S_DIFF_REV:
            begin
                sub_a = SW'(prev_reg);
                sub_b = SW'(ival_reg);
            end
            S_THRESH:
            begin
                sub_a = SW'(thresh_reg);
                sub_b = SW'(diff_reg);
            end
            S_DIVIDE:
            begin
                sub_a = SW'(partial);
                sub_b = SW'(target);
            end
            default:
            begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
    end

    assign sub_full   = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_res    = sub_full[SW-1:0];
    assign sub_borrow = sub_full[SW];

    assign icnt_next = icnt_reg + COUNT_W'(1);
    assign ecnt_next = ecnt_reg + COUNT_W'(exceeded_reg);
    assign pct_next  = (quot_reg > DIVD_W'(PCT_MAX)) ? PCT_MAX : quot_reg[PERCENT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            thresh_reg     <= THRESH_RESET;
            ipr_reg        <= IPR_RESET;
            seen_first_reg <= 1'b0;
            last_cap_reg   <= '0;
            cap_reg        <= '0;
            ovf_reg        <= '0;
            ival_reg       <= '0;
            prev_reg       <= '0;
            diff_reg       <= '0;
            have_prev_reg  <= 1'b0;
            exceeded_reg   <= 1'b0;
            icnt_reg       <= '0;
            ecnt_reg       <= '0;
            ind_reg        <= 1'b0;
            finished_reg   <= 1'b0;
            done_reg       <= 1'b0;
            dvd_reg        <= '0;
            quot_reg       <= '0;
            rem_reg        <= '0;
            step_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_ival_reg   <= '0;
            out_exc_reg    <= 1'b0;
            out_icnt_reg   <= '0;
            out_ecnt_reg   <= '0;
            out_ind_reg    <= 1'b0;
            out_done_reg   <= 1'b0;
            out_pct_reg    <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (cfg_idx)
                    REG_DIFF_THRESHOLD: thresh_reg <= pwdata[THRESH_W-1:0];
                    REG_INTERVALS:      ipr_reg    <= pwdata[COUNT_W-1:0];
                    default:            ;
                endcase
            end

            // drop the word once taken; a load in S_EMIT replaces it instead
            if (out_valid_reg && !out_stall && (state_reg != S_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc && !finished_reg)
                    begin
                        if (req_type == REQ_OVERFLOW)
                        begin
                            if (ovf_reg != '1)
                            begin
                                ovf_reg <= ovf_reg + OVF_W'(1);
                            end
                        end
                        else if (!seen_first_reg)
                        begin
                            seen_first_reg <= 1'b1;
                            last_cap_reg   <= capture_time[CAP_W-1:0];
                            ovf_reg        <= '0;
                        end
                        else
                        begin
                            cap_reg   <= capture_time[CAP_W-1:0];
                            state_reg <= S_INTERVAL;
                        end
                    end
                end
                S_INTERVAL:
                begin
                    // lost overflow gives zero; saturate above the interval range
                    if (sub_borrow)
                    begin
                        ival_reg <= '0;
                    end
                    else if ((sub_res >> INTERVAL_BITS) != '0)
                    begin
                        ival_reg <= '1;
                    end
                    else
                    begin
                        ival_reg <= sub_res[INTERVAL_BITS-1:0];
                    end
                    last_cap_reg <= cap_reg;
                    ovf_reg      <= '0;
                    exceeded_reg <= 1'b0;
                    state_reg    <= have_prev_reg ? S_DIFF_FWD : S_UPDATE;
                end
                S_DIFF_FWD:
                begin
                    diff_reg  <= sub_res[INTERVAL_BITS-1:0];
                    state_reg <= sub_borrow ? S_DIFF_REV : S_THRESH;
                end
                S_DIFF_REV:
                begin
                    diff_reg  <= sub_res[INTERVAL_BITS-1:0];
                    state_reg <= S_THRESH;
                end
                S_THRESH:
                begin
                    // threshold minus diff borrows when diff is larger
                    exceeded_reg <= sub_borrow;
                    state_reg    <= S_UPDATE;
                end
                S_UPDATE:
                begin
                    prev_reg      <= ival_reg;
                    have_prev_reg <= 1'b1;
                    icnt_reg      <= icnt_next;
                    ecnt_reg      <= ecnt_next;
                    if (exceeded_reg)
                    begin
                        ind_reg <= !ind_reg;
                    end
                    done_reg <= (icnt_next >= target);
                    dvd_reg  <= DIVD_W'(ecnt_next) * PCT_SCALE;
                    quot_reg <= '0;
                    rem_reg  <= '0;
                    step_reg <= DIV_STEP_W'(DIVD_W - 1);
                    if (icnt_next >= target)
                    begin
                        finished_reg <= 1'b1;
                        state_reg    <= S_DIVIDE;
                    end
                    else
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_DIVIDE:
                begin
                    // one restoring step per cycle
                    if (sub_borrow)
                    begin
                        rem_reg <= partial[COUNT_W-1:0];
                    end
                    else
                    begin
                        rem_reg <= sub_res[COUNT_W-1:0];
                    end
                    quot_reg <= {quot_reg[DIVD_W-2:0], !sub_borrow};
                    dvd_reg  <= {dvd_reg[DIVD_W-2:0], 1'b0};
                    step_reg <= step_reg - DIV_STEP_W'(1);
                    if (step_reg == '0)
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        out_ival_reg  <= INTERVAL_W'(ival_reg);
                        out_exc_reg   <= exceeded_reg;
                        out_icnt_reg  <= icnt_reg;
                        out_ecnt_reg  <= ecnt_reg;
                        out_ind_reg   <= ind_reg;
                        out_done_reg  <= done_reg;
                        out_pct_reg   <= done_reg ? pct_next : '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid         = out_valid_reg;
    assign interval_ticks    = out_ival_reg;
    assign diff_exceeded     = out_exc_reg;
    assign counted_intervals = out_icnt_reg;
    assign exceeded_count    = out_ecnt_reg;
    assign indicator         = out_ind_reg;
    assign reading_valid     = out_done_reg;
    assign hrv_percent       = out_pct_reg;

    a_exc_le_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (exceeded_count <= counted_intervals) && (counted_intervals != '0))
        else $error("exceed count above interval count");

    a_first_no_exceed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && counted_intervals == COUNT_W'(1)) |-> !diff_exceeded)
        else $error("first interval flagged as exceeded");

    a_pct_gated: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !reading_valid) |-> (hrv_percent == '0))
        else $error("percentage outside a completed reading");

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hrv_percent <= PCT_MAX))
        else $error("percentage above full scale");

    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && finished_reg) |=> !in_stall)
        else $error("dropped word after reading left block busy");

endmodule

`default_nettype wire

// ----- verif/pim_beat_checker.sv -----
`timescale 1ns / 1ps

module pim_beat_checker
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [pim_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [pim_pkg::APB_DATA_W-1:0]   pwdata,
    input  wire logic                             pready,
    input  wire logic                             in_valid,
    input  wire logic                             in_stall,
    input  wire logic                             req_type,
    input  wire logic [pim_pkg::CAPTURE_W-1:0]    capture_time,
    input  wire logic                             out_valid,
    input  wire logic                             out_stall,
    input  wire logic [pim_pkg::INTERVAL_W-1:0]   interval_ticks,
    input  wire logic                             diff_exceeded,
    input  wire logic [pim_pkg::COUNT_W-1:0]      counted_intervals,
    input  wire logic [pim_pkg::COUNT_W-1:0]      exceeded_count,
    input  wire logic                             indicator,
    input  wire logic                             reading_valid,
    input  wire logic [pim_pkg::PERCENT_W-1:0]    hrv_percent,
    output int                                    fail_cnt,
    output int                                    pending,
    output int                                    checked,
    output logic      [pim_pkg::COUNT_W-1:0]      intervals_done,
    output logic                                  reading_done
);
    import pim_pkg::*;

    typedef struct packed {
        logic [INTERVAL_W-1:0] ival;
        logic                  exceeded;
        logic [COUNT_W-1:0]    counted;
        logic [COUNT_W-1:0]    exc;
        logic                  ind;
        logic                  done;
        logic [PERCENT_W-1:0]  pct;
    } beat_result_t;

    beat_result_t expected_beats[$];
    beat_result_t got_beat;
    beat_result_t want_beat;

    // predicted meter state and register copies
    logic [THRESH_W-1:0]   thresh       = THRESH_RESET;
    logic [COUNT_W-1:0]    per_reading  = IPR_RESET;
    logic                  seen_edge    = 1'b0;
    logic [CAPTURE_W-1:0]  last_cap     = '0;
    logic [OVF_W-1:0]      ovf_ticks    = '0;
    logic [INTERVAL_W-1:0] prev_ival    = '0;
    logic                  have_prev    = 1'b0;
    logic [COUNT_W-1:0]    ival_cnt     = '0;
    logic [COUNT_W-1:0]    exc_cnt      = '0;
    logic                  ind_level    = 1'b0;
    logic                  closed       = 1'b0;
    int                    fails        = 0;
    int                    matched      = 0;

    function void predict_beat(input logic rt, input logic [CAPTURE_W-1:0] cap);
        logic [INTERVAL_W-1:0] total;
        logic [INTERVAL_W-1:0] ival;
        logic [INTERVAL_W-1:0] delta;
        beat_result_t          r;
        int                    target;
        int                    pct;
        r = '0;
        if (closed)
            return;
        if (rt == REQ_OVERFLOW)
        begin
            if (ovf_ticks != '1)
                ovf_ticks++;
            return;
        end
        if (!seen_edge)
        begin
            seen_edge = 1'b1;
            last_cap  = cap;
            ovf_ticks = '0;
            return;
        end
        total = {ovf_ticks, cap};
        // a capture below the last one with no overflow seen gives zero
        ival = (total >= INTERVAL_W'(last_cap)) ? total - INTERVAL_W'(last_cap) : '0;
        last_cap  = cap;
        ovf_ticks = '0;
        if (have_prev)
        begin
            delta = (ival >= prev_ival) ? ival - prev_ival : prev_ival - ival;
            r.exceeded = delta > INTERVAL_W'(thresh);
        end
        prev_ival = ival;
        have_prev = 1'b1;
        ival_cnt++;
        if (r.exceeded)
        begin
            exc_cnt++;
            ind_level = ~ind_level;
        end
        target = (per_reading == '0) ? 1 : int'(per_reading);
        r.done = int'(ival_cnt) >= target;
        pct = 0;
        if (r.done)
        begin
            closed = 1'b1;
            pct = int'(exc_cnt) * int'(PCT_SCALE) / target;
            if (pct > int'(PCT_MAX))
                pct = int'(PCT_MAX);
        end
        r.ival    = ival;
        r.counted = ival_cnt;
        r.exc     = exc_cnt;
        r.ind     = ind_level;
        r.pct     = PERCENT_W'(pct);
        expected_beats.push_back(r);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_index_t'(paddr[APB_ADDR_W-1:2]))
                    REG_DIFF_THRESHOLD: thresh      = pwdata[THRESH_W-1:0];
                    REG_INTERVALS:      per_reading = pwdata[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                got_beat = {interval_ticks, diff_exceeded, counted_intervals,
                            exceeded_count, indicator, reading_valid, hrv_percent};
                if (expected_beats.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: unexpected result word, interval %0d", $realtime,
                                 interval_ticks);
                end
                else
                begin
                    want_beat = expected_beats.pop_front();
                    matched++;
                    if (got_beat !== want_beat)
                    begin
                        fails++;
                        if (fails <= 10)
                        begin
                            $display("%0t: MISMATCH exp/got interval %0d/%0d exceeded %b/%b",
                                     $realtime, want_beat.ival, got_beat.ival,
                                     want_beat.exceeded, got_beat.exceeded);
                            $display("    counted %0d/%0d exc %0d/%0d ind %b/%b",
                                     want_beat.counted, got_beat.counted,
                                     want_beat.exc, got_beat.exc,
                                     want_beat.ind, got_beat.ind);
                            $display("    done %b/%b pct %0d/%0d",
                                     want_beat.done, got_beat.done,
                                     want_beat.pct, got_beat.pct);
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_beat(req_type, capture_time);
        end
        fail_cnt       <= fails;
        pending        <= expected_beats.size();
        checked        <= matched;
        intervals_done <= ival_cnt;
        reading_done   <= closed;
    end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import pim_pkg::*;

    localparam int  HOLD_CYCLES    = 300;
    localparam int  WATCHDOG_LIMIT = 5000;
    localparam int  SETTLE_CYCLES  = 40;
    localparam int  PHASES         = 8;
    localparam int  PHASE_WORDS    = 215;
    localparam int  PHASE_BEATS    = 26;
    localparam int  BURST_TICKS    = 40;
    localparam longint MAX_PERIOD  = 64'd16 * 65536;

    logic                    clk;
    logic                    rst_n        = 1'b0;
    logic                    psel         = 1'b0;
    logic                    penable      = 1'b0;
    logic                    pwrite       = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr        = '0;
    logic [APB_DATA_W-1:0]   pwdata       = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;
    logic                    in_valid     = 1'b0;
    logic                    in_stall;
    logic                    req_type     = 1'b0;
    logic [CAPTURE_W-1:0]    capture_time = '0;
    logic                    out_valid;
    logic                    out_stall    = 1'b0;
    logic [INTERVAL_W-1:0]   interval_ticks;
    logic                    diff_exceeded;
    logic [COUNT_W-1:0]      counted_intervals;
    logic [COUNT_W-1:0]      exceeded_count;
    logic                    indicator;
    logic                    reading_valid;
    logic [PERCENT_W-1:0]    hrv_percent;

    int                      fail_cnt;
    int                      pending;
    int                      checked;
    logic [COUNT_W-1:0]      intervals_done;
    logic                    reading_done;

    bit                      quiet     = 1'b0;
    bit                      hold_req  = 1'b0;
    int                      words_sent = 0;
    int                      reg_writes = 0;
    longint                  t_now     = 0;
    longint                  period    = 65536;
    int                      jitter    = 1000;

    pnn50_interval_meter i_dut (.*);

    pim_beat_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_word(input logic rt, input logic [CAPTURE_W-1:0] cap);
        int gap;
        in_valid     <= 1'b1;
        req_type     <= rt;
        capture_time <= cap;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
        gap = idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic reg_write(input reg_index_t idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        reg_writes++;
        @(posedge clk);
    endtask

    // Hold input off until every result is back and the sequencer is quiet
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One beat on a virtual free-running timer: overflow ticks, then the edge
    task automatic send_beat();
        longint                nxt;
        int                    wraps;
        int                    r;
        logic [CAPTURE_W-1:0]  cap;
        r = $urandom_range(0, 99);
        if (r < 85)
        begin
            if (r < 60)
                period = period + longint'($urandom_range(0, 2 * jitter)) - jitter;
            else
                period = longint'($urandom_range(0, 12)) * 65536
                         + longint'($urandom_range(0, 65535));
            if (period < 0)
                period = 0;
            if (period > MAX_PERIOD)
                period = MAX_PERIOD;
            nxt   = t_now + period;
            wraps = int'((nxt >> 16) - (t_now >> 16));
            cap   = nxt[15:0];
            t_now = nxt;
        end
        else
        begin
            // broken beat: random capture, few or missing overflow ticks
            wraps = $urandom_range(0, 2);
            cap   = CAPTURE_W'($urandom());
            t_now = longint'(cap);
        end
        repeat (wraps) send_word(REQ_OVERFLOW, CAPTURE_W'($urandom()));
        send_word(REQ_EDGE, cap);
    endtask

    initial
    begin : result_sink
        int n;
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            n = idle_len();
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
                idle = 0;
            else
                idle++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : stimulus
        int                  start;
        int                  beats;
        int                  mode;
        logic [COUNT_W-1:0]  last_setting;
        logic [THRESH_W-1:0] th;
        rst_n <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero threshold, long reading
        reg_write(REG_DIFF_THRESHOLD, {8'($urandom()), 24'd0});
        reg_write(REG_INTERVALS, {24'($urandom()), 8'd255});
        send_word(REQ_OVERFLOW, 16'hFFFF);
        send_word(REQ_OVERFLOW, 16'h0000);
        send_word(REQ_EDGE, 16'hFFFF);      // first edge: no result
        send_word(REQ_EDGE, 16'h0000);      // lost overflow, first interval
        send_word(REQ_OVERFLOW, 16'h1234);
        send_word(REQ_EDGE, 16'hFFFF);
        send_word(REQ_EDGE, 16'hFFFF);
        send_word(REQ_EDGE, 16'hFFFF);      // zero difference at zero threshold
        send_word(REQ_EDGE, 16'h8000);
        send_word(REQ_OVERFLOW, 16'h0000);
        send_word(REQ_OVERFLOW, 16'hFFFF);
        send_word(REQ_EDGE, 16'h5555);
        send_word(REQ_OVERFLOW, 16'hAAAA);
        send_word(REQ_EDGE, 16'hAAAA);
        send_word(REQ_EDGE, 16'hAAAA);
        t_now = 64'hAAAA;

        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            case (ph)
                1:       th = '1;
                2:       th = 24'd1;
                7:       th = THRESH_W'($urandom_range(0, 24'hFFFFFF));
                default: th = THRESH_W'($urandom_range(0, 400000));
            endcase
            reg_write(REG_DIFF_THRESHOLD, {8'($urandom()), th});
            if (ph % 3 == 0)
                reg_write(REG_INTERVALS, {24'($urandom()), 8'(255 - 5 * ph)});
            case ($urandom_range(0, 3))
                0:       jitter = 0;
                1:       jitter = 300;
                2:       jitter = 30000;
                default: jitter = 150000;
            endcase
            quiet = (ph == 2 || ph == 5);
            if (ph == 5)
                hold_req = 1'b1;
            beats = 0;
            if (ph == 1)
            begin
                // a run of overflow ticks, then close a long interval
                quiet = 1'b1;
                repeat (BURST_TICKS) send_word(REQ_OVERFLOW, CAPTURE_W'($urandom()));
                quiet = 1'b0;
                send_word(REQ_EDGE, CAPTURE_W'($urandom()));
                beats++;
                t_now = 0;
            end
            start = words_sent;
            while (words_sent - start < PHASE_WORDS)
            begin
                if (beats < PHASE_BEATS)
                begin
                    send_beat();
                    beats++;
                end
                else
                    send_word(REQ_OVERFLOW, CAPTURE_W'($urandom()));
            end
        end

        // close the reading: zero count, count at or below progress, or just above it
        settle();
        quiet = 1'b0;
        mode = $urandom_range(0, 2);
        case (mode)
            0:       last_setting = '0;
            1:       last_setting = COUNT_W'($urandom_range(1, int'(intervals_done)));
            default: last_setting = intervals_done + COUNT_W'($urandom_range(1, 3));
        endcase
        reg_write(REG_INTERVALS, {24'($urandom()), last_setting});
        while (!reading_done)
            send_beat();
        // words after the reading closed must be dropped
        repeat (20) send_word(1'($urandom_range(0, 1)), CAPTURE_W'($urandom()));
        settle();

        $display("Run covered %0d words, %0d register writes and %0d checked intervals;",
                 words_sent, reg_writes, checked);
        $display("the reading closed at %0d intervals with the count register at %0d.",
                 intervals_done, last_setting);
        if (fail_cnt == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- pnn50_interval_meter.f -----
hw/rtl/pim_pkg.sv
hw/rtl/pnn50_interval_meter.sv
verif/pim_beat_checker.sv
verif/tb_top.sv
